// ===== design/dmm_pkg.sv =====
// shared types and constants for the dense matrix multiply unit
// no dependencies
package dmm_pkg;

    localparam int FUNC_W      = 2;
    localparam int IDX_FIELD_W = 6;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int SUM_W       = 38;
    localparam int CFG_W       = 7;
    localparam int MAX_DIM_DEF = 64;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_LOAD_A  = 2'd0;
    localparam t_func FUNC_LOAD_B  = 2'd1;
    localparam t_func FUNC_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic shift;
    } t_lane_ctrl;

endpackage

// ===== design/dmm_cfg_if.sv =====
// configuration write channel carrying the size register word
// depends on dmm_pkg
interface dmm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dmm_pkg::CFG_W-1:0]   size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface

// ===== design/dmm_in_if.sv =====
// input channel: load and compute words
// depends on dmm_pkg
interface dmm_in_if;
    logic                                valid;
    logic                                ready;
    logic [dmm_pkg::FUNC_W-1:0]          func;
    logic [dmm_pkg::IDX_FIELD_W-1:0]     row_index;
    logic [dmm_pkg::IDX_FIELD_W-1:0]     col_index;
    logic signed [dmm_pkg::ELEM_W-1:0]   elem_value;

    modport source (output valid, output func, output row_index, output col_index,
                    output elem_value, input ready);
    modport sink   (input valid, input func, input row_index, input col_index,
                    input elem_value, output ready);
endinterface

// ===== design/dmm_out_if.sv =====
// result channel: one product element per word
// depends on dmm_pkg
interface dmm_out_if;
    logic                                valid;
    logic                                ready;
    logic [dmm_pkg::IDX_FIELD_W-1:0]     out_row;
    logic [dmm_pkg::IDX_FIELD_W-1:0]     out_col;
    logic signed [dmm_pkg::SUM_W-1:0]    product_sum;
    logic                                last_of_row;

    modport source (output valid, output out_row, output out_col, output product_sum,
                    output last_of_row, input ready);
    modport sink   (input valid, input out_row, input out_col, input product_sum,
                    input last_of_row, output ready);
endinterface

// ===== design/dmm_lane_array.sv =====
// one multiply-accumulate lane per column of C, with a shift-out path
// depends on dmm_pkg
module dmm_lane_array #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  logic                                      i_clk,
    input  dmm_pkg::t_lane_ctrl                       i_ctrl,
    input  logic signed [dmm_pkg::ELEM_W-1:0]         i_a,
    input  logic [MAX_DIM-1:0][dmm_pkg::ELEM_W-1:0]   i_b_row,
    output logic signed [dmm_pkg::SUM_W-1:0]          o_head
);
    import dmm_pkg::*;

    logic signed [PROD_W-1:0] r_prod [MAX_DIM];
    logic signed [SUM_W-1:0]  r_acc  [MAX_DIM];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            for (int j = 0; j < MAX_DIM; j++) begin
                r_prod[j] <= PROD_W'(i_a * $signed(i_b_row[j]));
            end
        end
    end

    // lane 0 is always the next column to leave
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            for (int j = 0; j < MAX_DIM; j++) begin
                r_acc[j] <= '0;
            end
        end else if (i_ctrl.acc_en) begin
            for (int j = 0; j < MAX_DIM; j++) begin
                r_acc[j] <= r_acc[j] + SUM_W'(r_prod[j]);
            end
        end else if (i_ctrl.shift) begin
            for (int j = 0; j < MAX_DIM - 1; j++) begin
                r_acc[j] <= r_acc[j + 1];
            end
            r_acc[MAX_DIM-1] <= '0;
        end
    end

    assign o_head = r_acc[0];

endmodule

// ===== design/dense_matrix_multiply_unit.sv =====
// dense matrix multiply unit: A and B in on-chip memories, C produced a row at a time
// load word: written to memory, no result. compute word: memory reads for k = 0..n-1
// (one A element and one full B row per cycle into MAX_DIM parallel MACs), a drain
// until the read and product stages are empty, then n result words, one per cycle
// when taken. one word is in flight at a time. synchronous active-low reset returns
// to idle with size n = MAX_DIM; memory contents are not cleared.
module dense_matrix_multiply_unit #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dmm_cfg_if.sink   i_cfg_ch,
    dmm_in_if.sink    i_in_ch,
    dmm_out_if.source o_out_ch
);
    import dmm_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [ELEM_W-1:0]              r_mem_a [MAX_DIM][MAX_DIM];
    logic [MAX_DIM-1:0][ELEM_W-1:0] r_mem_b [MAX_DIM];

    t_state                     r_state, n_state;
    logic [DIM_W-1:0]           r_dim, n_dim;
    logic [IDX_FIELD_W-1:0]     r_row;
    logic [IDX_FIELD_W-1:0]     r_col;
    logic [IDX_W-1:0]           r_k;
    logic                       r_rd_vld;
    logic                       r_mul_vld;
    logic signed [ELEM_W-1:0]   r_a_q;
    logic [MAX_DIM-1:0][ELEM_W-1:0] r_b_q;

    logic [CFG_W-1:0]           dim_ext;
    logic                       in_acc, out_acc, cfg_acc;
    logic                       row_ok, col_ok;
    logic                       start, we_a, we_b;
    logic                       k_last, col_last;
    logic                       rd_en;
    t_lane_ctrl                 lane_ctrl;
    logic signed [SUM_W-1:0]    head;

    assign dim_ext = CFG_W'(r_dim);
    assign in_acc  = i_in_ch.valid && i_in_ch.ready;
    assign out_acc = o_out_ch.valid && o_out_ch.ready;
    assign cfg_acc = i_cfg_ch.valid && i_cfg_ch.ready;
    assign row_ok  = CFG_W'(i_in_ch.row_index) < dim_ext;
    assign col_ok  = CFG_W'(i_in_ch.col_index) < dim_ext;
    assign start   = in_acc && (i_in_ch.func == FUNC_COMPUTE) && row_ok;
    assign we_a    = in_acc && (i_in_ch.func == FUNC_LOAD_A) && row_ok && col_ok;
    assign we_b    = in_acc && (i_in_ch.func == FUNC_LOAD_B) && row_ok && col_ok;
    assign k_last  = (CFG_W'(r_k) + CFG_W'(1)) == dim_ext;
    assign col_last = (CFG_W'(r_col) + CFG_W'(1)) == dim_ext;

    // size register, clamped into 1..MAX_DIM on write
    always_comb begin
        if (i_cfg_ch.size_in_use == '0) begin
            n_dim = DIM_W'(1);
        end else if (i_cfg_ch.size_in_use > CFG_W'(MAX_DIM)) begin
            n_dim = DIM_W'(MAX_DIM);
        end else begin
            n_dim = DIM_W'(i_cfg_ch.size_in_use);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_W'(MAX_DIM);
        end else if (cfg_acc) begin
            r_dim <= n_dim;
        end
    end

    // element memories: A by element, B by element into a row-wide word
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[i_in_ch.row_index[IDX_W-1:0]][i_in_ch.col_index[IDX_W-1:0]] <=
                i_in_ch.elem_value;
        end
        if (rd_en) begin
            r_a_q <= r_mem_a[r_row[IDX_W-1:0]][r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[i_in_ch.row_index[IDX_W-1:0]][i_in_ch.col_index[IDX_W-1:0]] <=
                i_in_ch.elem_value;
        end
        if (rd_en) begin
            r_b_q <= r_mem_b[r_k];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= rd_en;
            r_mul_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row <= i_in_ch.row_index;
            r_k   <= '0;
            r_col <= '0;
        end else begin
            if (rd_en) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (out_acc) begin
                r_col <= r_col + IDX_FIELD_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_mul_vld) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_acc && col_last) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        i_in_ch.ready  = 1'b0;
        o_out_ch.valid = 1'b0;
        rd_en          = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_in_ch.ready  = 1'b1;
            ST_MAC:   rd_en          = 1'b1;
            ST_DRAIN: rd_en          = 1'b0;
            ST_OUT:   o_out_ch.valid = 1'b1;
        endcase
    end

    assign i_cfg_ch.ready = 1'b1;

    assign lane_ctrl.clear  = start;
    assign lane_ctrl.mul_en = r_rd_vld;
    assign lane_ctrl.acc_en = r_mul_vld;
    assign lane_ctrl.shift  = out_acc;

    dmm_lane_array #(
        .MAX_DIM (MAX_DIM)
    ) u_lanes (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_a     (r_a_q),
        .i_b_row (r_b_q),
        .o_head  (head)
    );

    assign o_out_ch.out_row     = r_row;
    assign o_out_ch.out_col     = r_col;
    assign o_out_ch.product_sum = head;
    assign o_out_ch.last_of_row = col_last;

endmodule

// ===== design/dmm_checker.sv =====
// port-level checks on the dense matrix multiply unit, bound to the top level
// depends on dmm_pkg and the channel interfaces
module dmm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [dmm_pkg::IDX_FIELD_W-1:0]    i_out_row,
    input logic [dmm_pkg::IDX_FIELD_W-1:0]    i_out_col,
    input logic                               i_out_last
);
    import dmm_pkg::*;

    // one word at a time: no new input while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result word is offered");

    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (i_out_col == '0))
        else $error("row of results does not start at column zero");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && (i_out_col == IDX_FIELD_W'($past(i_out_col) + 1'b1))))
        else $error("result columns not consecutive");

    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_row == $past(i_out_row)))
        else $error("row changed within a row of results");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (i_in_ready && !i_out_valid))
        else $error("not idle after the last column");

endmodule

bind dense_matrix_multiply_unit dmm_checker u_dmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_row   (o_out_ch.out_row),
    .i_out_col   (o_out_ch.out_col),
    .i_out_last  (o_out_ch.last_of_row)
);
